// ===== design/bcs_pkg.sv =====
// Shared types and constants of the bitmap change scanner.
package bcs_pkg;

  localparam int MAX_ELEMENTS_DEF = 256;
  localparam int COUNT_W = 9;
  localparam int DELAY_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [DELAY_W-1:0] RESET_DELAY = 16'd5;
  localparam logic [2:0] BIT_SEL_MASK = 3'd7;

  localparam logic [2:0] CMD_STEP = 3'd0;
  localparam logic [2:0] CMD_TICK = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_START = 3'd3;
  localparam logic [2:0] CMD_BREAK = 3'd4;
  localparam logic [2:0] CMD_DONE = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_SEQUIN_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TICKS = 2'd1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [4:0] byte_index;
    logic [7:0] byte_value;
  } in_word_t;

  typedef struct packed {
    logic       request;
    logic [7:0] element_index;
    logic       new_color;
    logic       finished;
    logic       busy_res;
  } out_word_t;

endpackage

// ===== design/bitmap_change_scanner_unit.sv =====
// Top level of the bitmap change scanner: command decode, scan sequencer and bitmap memories.
//
// Usage: each word on the in_ channel is one command (step, tick, target byte write,
// start, break, update complete). Every accepted word yields exactly one word on the
// out_ channel, in order. The cfg_ channel writes the element count and the delay
// between element updates; the user must write it only while no command is in
// flight, as the block itself does not enforce it. A word that does not scan has its
// result written into the output queue in the cycle it is accepted. A step that scans
// reads the current and target bitmaps one byte per cycle from their synchronous
// memories until it finds a changed element or reaches the count. One command is in flight
// at a time; the next is taken when its result has been queued.
// Results go into a two-word output queue, so a new command is accepted while one
// result waits; when the receiver stalls and the queue is full, in_ready drops.
// Reset clears both bitmaps at once through per-byte valid flags, resets the
// sequencer flags and loads the delay register with five ticks.
module bitmap_change_scanner_unit #(
  parameter int MAX_ELEMENTS = bcs_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bcs_pkg::in_word_t                  in_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bcs_pkg::out_word_t                 out_word,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bcs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int COUNT_MAX = (1 << bcs_pkg::COUNT_W) - 1;
  localparam int LIMIT_MAX = (MAX_ELEMENTS < COUNT_MAX) ? MAX_ELEMENTS : COUNT_MAX;
  localparam int POS_W = $clog2(LIMIT_MAX + 1);
  localparam int DEPTH = (LIMIT_MAX + 7) / 8;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bcs_pkg::state_t state_r, state_nxt;

  logic [bcs_pkg::COUNT_W-1:0] seq_cnt_r;
  logic [bcs_pkg::DELAY_W-1:0] dticks_r;
  logic                        active_r, active_nxt;
  logic                        idle_r, idle_nxt;
  logic [POS_W-1:0]            pos_r, pos_nxt;
  logic                        started_r, started_nxt;
  logic                        done_r, done_nxt;
  logic [bcs_pkg::DELAY_W-1:0] dcnt_r, dcnt_nxt;
  logic                        expired_r, expired_nxt;

  logic [7:0]       cur_mem [DEPTH];
  logic [7:0]       tgt_mem [DEPTH];
  logic [DEPTH-1:0] cur_vld_r;
  logic [DEPTH-1:0] tgt_vld_r;
  logic [7:0]       cur_q_r, tgt_q_r;
  logic             cur_qv_r, tgt_qv_r;

  logic              cur_we, tgt_we;
  logic [ADDR_W-1:0] cur_wa, tgt_wa, rd_addr;
  logic [7:0]        cur_wd;

  bcs_pkg::out_word_t q_r [2];
  logic [1:0]         cnt_r;
  logic               push, pop;
  bcs_pkg::out_word_t push_word;

  logic             in_acc;
  logic [POS_W-1:0] limit_w;
  logic [POS_W-1:0] base_w;
  logic [POS_W:0]   next_base;
  logic [POS_W-1:0] pos_after;
  logic [7:0]       cur_b, tgt_b, cand;
  logic             found;
  logic [2:0]       found_bit;
  logic [POS_W-1:0] elem_w;

  assign in_acc = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign in_ready = (state_r == bcs_pkg::ST_IDLE) && (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_word = q_r[0];
  assign pop = out_valid && out_ready;

  assign limit_w = (32'(seq_cnt_r) > LIMIT_MAX) ? POS_W'(LIMIT_MAX) : POS_W'(seq_cnt_r);
  assign base_w = pos_r & ~POS_W'(bcs_pkg::BIT_SEL_MASK);
  assign next_base = (POS_W + 1)'(base_w) + (POS_W + 1)'(8);
  assign pos_after = (next_base >= (POS_W + 1)'(limit_w)) ? limit_w : POS_W'(next_base);
  assign cur_b = cur_qv_r ? cur_q_r : 8'd0;
  assign tgt_b = tgt_qv_r ? tgt_q_r : 8'd0;

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      cand[j] = (cur_b[j] ^ tgt_b[j]) && (3'(j) >= pos_r[2:0]) &&
                ((base_w | POS_W'(j)) < limit_w);
    end
  end

  always_comb begin
    found = 1'b0;
    found_bit = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (cand[j]) begin
        found = 1'b1;
        found_bit = 3'(j);
      end
    end
  end

  assign elem_w = base_w | POS_W'(found_bit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_cnt_r <= '0;
      dticks_r <= bcs_pkg::RESET_DELAY;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bcs_pkg::CFG_SEQUIN_COUNT) begin
        seq_cnt_r <= cfg_data[bcs_pkg::COUNT_W-1:0];
      end else if (cfg_index == bcs_pkg::CFG_DELAY_TICKS) begin
        dticks_r <= cfg_data[bcs_pkg::DELAY_W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    active_nxt = active_r;
    idle_nxt = idle_r;
    pos_nxt = pos_r;
    started_nxt = started_r;
    done_nxt = done_r;
    dcnt_nxt = dcnt_r;
    expired_nxt = expired_r;
    rd_addr = ADDR_W'(pos_r >> 3);
    cur_we = 1'b0;
    cur_wa = ADDR_W'(pos_r >> 3);
    cur_wd = cur_b;
    tgt_we = 1'b0;
    tgt_wa = ADDR_W'(in_word.byte_index);
    push = 1'b0;
    push_word = '0;
    unique case (state_r)
      bcs_pkg::ST_IDLE: begin
        if (in_acc) begin
          push = 1'b1;
          unique case (in_word.cmd)
            bcs_pkg::CMD_STEP: begin
              if (!active_r) begin
                push = 1'b1;
              end else if (idle_r) begin
                idle_nxt = 1'b0;
                pos_nxt = '0;
              end else if (pos_r >= limit_w) begin
                idle_nxt = 1'b1;
                active_nxt = 1'b0;
                push_word.finished = 1'b1;
              end else if (!expired_r) begin
                push = 1'b1;
              end else if (done_r) begin
                dcnt_nxt = dticks_r;
                expired_nxt = 1'b0;
                started_nxt = 1'b0;
                done_nxt = 1'b0;
              end else if (!started_r) begin
                push = 1'b0;
                state_nxt = bcs_pkg::ST_SCAN;
              end
            end
            bcs_pkg::CMD_TICK: begin
              if (dcnt_r != '0) begin
                dcnt_nxt = dcnt_r - 16'd1;
              end
              if (dcnt_r <= 16'd1) begin
                expired_nxt = 1'b1;
              end
            end
            bcs_pkg::CMD_WRITE: begin
              tgt_we = (32'(in_word.byte_index) < DEPTH);
            end
            bcs_pkg::CMD_START: begin
              active_nxt = 1'b1;
            end
            bcs_pkg::CMD_BREAK: begin
              active_nxt = 1'b0;
              idle_nxt = 1'b1;
              dcnt_nxt = '0;
            end
            bcs_pkg::CMD_DONE: begin
              done_nxt = 1'b1;
            end
            default: begin
              push = 1'b1;
            end
          endcase
          push_word.busy_res = active_nxt;
        end
      end
      bcs_pkg::ST_SCAN: begin
        push_word.busy_res = active_r;
        if (found) begin
          cur_we = 1'b1;
          cur_wd = cur_b ^ (8'd1 << found_bit);
          pos_nxt = elem_w;
          started_nxt = 1'b1;
          done_nxt = 1'b0;
          push = 1'b1;
          push_word.request = 1'b1;
          push_word.element_index = 8'(elem_w);
          push_word.new_color = tgt_b[found_bit];
          state_nxt = bcs_pkg::ST_IDLE;
        end else begin
          pos_nxt = pos_after;
          rd_addr = ADDR_W'(pos_after >> 3);
          if (pos_after >= limit_w) begin
            push = 1'b1;
            state_nxt = bcs_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = bcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcs_pkg::ST_IDLE;
      active_r <= 1'b0;
      idle_r <= 1'b1;
      pos_r <= '0;
      started_r <= 1'b0;
      done_r <= 1'b0;
      dcnt_r <= '0;
      expired_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      active_r <= active_nxt;
      idle_r <= idle_nxt;
      pos_r <= pos_nxt;
      started_r <= started_nxt;
      done_r <= done_nxt;
      dcnt_r <= dcnt_nxt;
      expired_r <= expired_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[cur_wa] <= cur_wd;
    end
    cur_q_r <= cur_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[tgt_wa] <= in_word.byte_value;
    end
    tgt_q_r <= tgt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= '0;
      tgt_vld_r <= '0;
      cur_qv_r <= 1'b0;
      tgt_qv_r <= 1'b0;
    end else begin
      if (cur_we) begin
        cur_vld_r[cur_wa] <= 1'b1;
      end
      if (tgt_we) begin
        tgt_vld_r[tgt_wa] <= 1'b1;
      end
      cur_qv_r <= cur_vld_r[rd_addr];
      tgt_qv_r <= tgt_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop && push) begin
      if (cnt_r == 2'd2) begin
        q_r[0] <= q_r[1];
        q_r[1] <= push_word;
      end else begin
        q_r[0] <= push_word;
      end
    end else if (pop) begin
      q_r[0] <= q_r[1];
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        q_r[0] <= push_word;
      end else begin
        q_r[1] <= push_word;
      end
    end
  end

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != 2'd2) || pop)
    else $error("Result pushed into a full output queue.");

  a_write_reports: assert property (@(posedge clk) disable iff (!rst_n)
    cur_we |-> push && push_word.request && started_nxt)
    else $error("Current bitmap changed without a request result.");

  a_finish_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_word.finished) |-> !push_word.busy_res && !push_word.request)
    else $error("Finished result still reports an active pass.");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bcs_pkg::ST_SCAN) |-> (pos_r < limit_w) && active_r && !started_r)
    else $error("Scan running outside the element range.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (state_nxt == bcs_pkg::ST_SCAN)) |=> !in_ready)
    else $error("Command accepted while a scan is in flight.");

endmodule
